FILE: rtl/iafd_pkg.sv
// ============================================================================
// iafd_pkg
// Shared types and constants for the integer ALU with floor division.
// ============================================================================
package iafd_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_WIDTH       = 3;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_LT  = 3'd4,
        OP_GT  = 3'd5
    } t_op;

    // control that travels down the chain with each request
    typedef struct packed {
        logic valid;
        t_op  op;
        logic neg_q;
        logic dz;
    } t_ctl;

endpackage

FILE: rtl/iafd_front.sv
// ============================================================================
// iafd_front
// Entry stage: decodes the request, finishes add, subtract and compares,
// and loads operands for the multiply and divide chain.
// ============================================================================
module iafd_front import iafd_pkg::*; #(
    parameter int W = DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [OP_WIDTH-1:0] i_req_type,
    input  logic [W-1:0]        i_operand_a,
    input  logic [W-1:0]        i_operand_b,
    output t_ctl                o_ctl,
    output logic [W-1:0]        o_acc,
    output logic [W-1:0]        o_x,
    output logic [W-1:0]        o_y
);

    t_ctl         r_ctl, n_ctl;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_x, n_x;
    logic [W-1:0] r_y, n_y;
    logic [W-1:0] mag_a, mag_b;
    logic         a_lt_b, b_lt_a;
    t_op          op;

    assign op     = t_op'(i_req_type);
    assign mag_a  = i_operand_a[W-1] ? (~i_operand_a + {{(W-1){1'b0}}, 1'b1}) : i_operand_a;
    assign mag_b  = i_operand_b[W-1] ? (~i_operand_b + {{(W-1){1'b0}}, 1'b1}) : i_operand_b;
    assign a_lt_b = $signed(i_operand_a) < $signed(i_operand_b);
    assign b_lt_a = $signed(i_operand_b) < $signed(i_operand_a);

    always_comb begin
        n_ctl.valid = i_valid;
        n_ctl.op    = op;
        n_ctl.neg_q = i_operand_a[W-1] ^ i_operand_b[W-1];
        n_ctl.dz    = 1'b0;
        n_acc       = '0;
        n_x         = '0;
        n_y         = '0;
        case (op)
            OP_ADD: begin
                n_acc = i_operand_a + i_operand_b;
            end
            OP_SUB: begin
                n_acc = i_operand_a - i_operand_b;
            end
            OP_MUL: begin
                n_x = i_operand_b;
                n_y = i_operand_a;
            end
            OP_DIV: begin
                n_ctl.dz = (i_operand_b == '0);
                n_x      = mag_a;
                n_y      = mag_b;
            end
            OP_LT: begin
                n_acc = {{(W-1){1'b0}}, a_lt_b};
            end
            OP_GT: begin
                n_acc = {{(W-1){1'b0}}, b_lt_a};
            end
            default: begin
                n_acc = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_ctl = r_ctl;
    assign o_acc = r_acc;
    assign o_x   = r_x;
    assign o_y   = r_y;

endmodule

FILE: rtl/iafd_cell.sv
// ============================================================================
// iafd_cell
// One step of the chain: a shift-add multiply step or a restoring divide
// step; other requests pass through unchanged.
// ============================================================================
module iafd_cell import iafd_pkg::*; #(
    parameter int W = DATA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctl         i_ctl,
    input  logic [W-1:0] i_acc,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    output t_ctl         o_ctl,
    output logic [W-1:0] o_acc,
    output logic [W-1:0] o_x,
    output logic [W-1:0] o_y
);

    t_ctl         r_ctl;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_x, n_x;
    logic [W-1:0] r_y, n_y;
    logic [W:0]   trial;
    logic [W:0]   diff;

    // acc: remainder / partial product, x: dividend-quotient / multiplier
    assign trial = {i_acc, i_x[W-1]};
    assign diff  = trial - {1'b0, i_y};

    always_comb begin
        n_acc = i_acc;
        n_x   = i_x;
        n_y   = i_y;
        case (i_ctl.op)
            OP_MUL: begin
                if (i_x[0]) begin
                    n_acc = i_acc + i_y;
                end
                n_x = i_x >> 1;
                n_y = i_y << 1;
            end
            OP_DIV: begin
                if (!diff[W]) begin
                    n_acc = diff[W-1:0];
                    n_x   = {i_x[W-2:0], 1'b1};
                end else begin
                    n_acc = trial[W-1:0];
                    n_x   = {i_x[W-2:0], 1'b0};
                end
            end
            default: begin
                n_acc = i_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_ctl = r_ctl;
    assign o_acc = r_acc;
    assign o_x   = r_x;
    assign o_y   = r_y;

endmodule

FILE: rtl/iafd_back.sv
// ============================================================================
// iafd_back
// Output stage: floor correction and sign of the quotient, zero-divisor
// handling and the registered result strobe.
// ============================================================================
module iafd_back import iafd_pkg::*; #(
    parameter int W = DATA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctl         i_ctl,
    input  logic [W-1:0] i_acc,
    input  logic [W-1:0] i_x,
    output logic         o_valid,
    output logic [W-1:0] o_value,
    output logic         o_is_bool,
    output logic         o_dz
);

    logic         r_valid;
    logic [W-1:0] r_value, n_value;
    logic         r_is_bool, n_is_bool;
    logic         r_dz, n_dz;

    always_comb begin
        n_value   = i_acc;
        n_is_bool = 1'b0;
        n_dz      = 1'b0;
        case (i_ctl.op)
            OP_DIV: begin
                n_dz = i_ctl.dz;
                if (i_ctl.dz) begin
                    n_value = '0;
                end else if (i_ctl.neg_q) begin
                    // -(q + 1) == ~q when a remainder is left
                    n_value = (i_acc != '0) ? ~i_x : (~i_x + {{(W-1){1'b0}}, 1'b1});
                end else begin
                    n_value = i_x;
                end
            end
            OP_LT, OP_GT: begin
                n_is_bool = 1'b1;
            end
            default: begin
                n_value = i_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_is_bool <= n_is_bool;
        r_dz      <= n_dz;
    end

    assign o_valid   = r_valid;
    assign o_value   = r_value;
    assign o_is_bool = r_is_bool;
    assign o_dz      = r_dz;

endmodule

FILE: rtl/integer_alu_floor_divide.sv
// ============================================================================
// integer_alu_floor_divide
// Integer ALU: wrapping add, subtract, multiply, floor divide and signed
// less / greater compares.
// ============================================================================
// Usage:
//   A request is taken on a rising edge with start high and busy low. It
//   carries i_req_type and the two operands i_operand_a and i_operand_b.
//   Each request gives exactly one result on o_result_value,
//   o_result_is_bool and o_div_by_zero, shown for one cycle with
//   o_result_valid high.
//   Every operation passes through the same registered stages: one entry stage,
//   a chain of DATA_WIDTH cells that each do one multiply or divide bit,
//   and one output stage. Results leave in request order.
//   Throughput is one request per cycle while busy is low. Reset sets busy
//   high; the first edge with reset released clears it. Reset also clears
//   every stage's valid bit, so requests in flight are dropped.
//   The receiver cannot stall: each result is present for one cycle only.
// ============================================================================
module integer_alu_floor_divide import iafd_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_WIDTH-1:0]   i_req_type,
    input  logic [DATA_WIDTH-1:0] i_operand_a,
    input  logic [DATA_WIDTH-1:0] i_operand_b,
    output logic                  o_result_valid,
    output logic [DATA_WIDTH-1:0] o_result_value,
    output logic                  o_result_is_bool,
    output logic                  o_div_by_zero
);

    localparam int LATENCY = DATA_WIDTH + 2;

    logic                  r_busy;
    logic                  req_ok;
    t_ctl                  ctl_c [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] acc_c [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] x_c   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] y_c   [0:DATA_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign req_ok = start && !r_busy;

    iafd_front #(.W(DATA_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (req_ok),
        .i_req_type  (i_req_type),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_ctl       (ctl_c[0]),
        .o_acc       (acc_c[0]),
        .o_x         (x_c[0]),
        .o_y         (y_c[0])
    );

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        iafd_cell #(.W(DATA_WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_c[g]),
            .i_acc   (acc_c[g]),
            .i_x     (x_c[g]),
            .i_y     (y_c[g]),
            .o_ctl   (ctl_c[g+1]),
            .o_acc   (acc_c[g+1]),
            .o_x     (x_c[g+1]),
            .o_y     (y_c[g+1])
        );
    end

    iafd_back #(.W(DATA_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl_c[DATA_WIDTH]),
        .i_acc     (acc_c[DATA_WIDTH]),
        .i_x       (x_c[DATA_WIDTH]),
        .o_valid   (o_result_valid),
        .o_value   (o_result_value),
        .o_is_bool (o_result_is_bool),
        .o_dz      (o_div_by_zero)
    );

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_ok |-> ##LATENCY o_result_valid)
        else $error("request produced no result after the chain latency");

    a_lat_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(req_ok, LATENCY))
        else $error("result strobe without a matching request");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_div_by_zero) |->
            (o_result_value == '0) && !o_result_is_bool)
        else $error("zero-divisor result not cleared");

    a_bool_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_is_bool) |->
            (o_result_value[DATA_WIDTH-1:1] == '0) && !o_div_by_zero)
        else $error("compare result out of range");

endmodule
